>>> rtl/pctb_pkg.sv
package pctb_pkg;

	localparam int NUM_TIMERS  = 36;
	localparam int FAST_TIMERS = 21;
	localparam int FAST_EFF    = (FAST_TIMERS > NUM_TIMERS) ? NUM_TIMERS : FAST_TIMERS;
	localparam int TMR_AW      = $clog2(NUM_TIMERS);
	localparam int CNT_W       = $clog2(NUM_TIMERS + 1);

	localparam int VAL_W    = 8;
	localparam int IDX_W    = 6;
	localparam int RELOAD_W = 7;
	localparam logic [RELOAD_W-1:0] RELOAD_RST = 7'h14;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_WR_TIMER = 2'd1,
		OP_RD_TIMER = 2'd2,
		OP_WR_STOP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_RDWAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t                 op;
		logic [IDX_W-1:0]    idx;
		logic [VAL_W-1:0]    wval;
		logic [RELOAD_W-1:0] reload;
	} req_t;

	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] frame_num;
		logic [VAL_W-1:0] read_value;
		logic             skipped;
		logic             slow;
	} res_t;

endpackage

>>> rtl/pctb_ram.sv
module pctb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 36
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/pctb_seq.sv
module pctb_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  pctb_pkg::req_t req,
	output logic          req_ready,
	input  logic          res_take,
	output pctb_pkg::res_t res
);
	import pctb_pkg::*;

	state_t state_q, state_d;

	logic [VAL_W-1:0]  stop_q, prescaler_q, frame_q;
	logic [VAL_W-1:0]  read_val_q;
	logic              skip_q, slow_q;
	logic [CNT_W-1:0]  cnt_q, lim_q;
	logic [TMR_AW-1:0] addr_q;
	logic              inr_q;
	logic [NUM_TIMERS-1:0] vld_q;

	logic              rd_vld_s1;
	logic [TMR_AW-1:0] rd_addr_s1;

	logic              accept, in_range, issue;
	logic              res_valid;
	logic              ram_we, ram_re;
	logic [TMR_AW-1:0] ram_waddr, ram_raddr;
	logic [VAL_W-1:0]  ram_wdata, ram_rdata, cur_val;

	logic [VAL_W-1:0]  stop_dec, pre_dec;
	logic              tick_skip, tick_slow;

	assign accept   = req_valid && req_ready;
	assign in_range = 32'(req.idx) < 32'(NUM_TIMERS);

	assign stop_dec  = (stop_q != '0) ? stop_q - 8'd1 : stop_q;
	assign tick_skip = (stop_dec != '0);
	assign pre_dec   = prescaler_q - 8'd1;
	assign tick_slow = !tick_skip && pre_dec[7];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.op == OP_TICK && !tick_skip) begin
						state_d = ST_SWEEP;
					end else if (req.op == OP_RD_TIMER) begin
						state_d = ST_RDWAIT;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SWEEP: begin
				if (cnt_q == lim_q) begin
					state_d = ST_DONE;
				end
			end
			ST_RDWAIT: state_d = ST_DONE;
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready = 1'b0;
		issue     = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE:   req_ready = 1'b1;
			ST_SWEEP:  issue     = (cnt_q != lim_q);
			ST_RDWAIT: ;
			ST_DONE:   res_valid = 1'b1;
			default:   ;
		endcase
	end

	assign res = {res_valid, frame_q, read_val_q, skip_q, slow_q};

	// memory ports
	assign cur_val = vld_q[rd_addr_s1] ? ram_rdata : '0;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_addr_s1;
		ram_wdata = (cur_val != '0) ? cur_val - 8'd1 : '0;
		if (rd_vld_s1) begin
			ram_we = 1'b1;
		end else if (accept && req.op == OP_WR_TIMER && in_range) begin
			ram_we    = 1'b1;
			ram_waddr = TMR_AW'(req.idx);
			ram_wdata = req.wval;
		end
	end

	assign ram_re    = issue || (accept && req.op == OP_RD_TIMER && in_range);
	assign ram_raddr = issue ? cnt_q[TMR_AW-1:0] : TMR_AW'(req.idx);

	pctb_ram #(
		.WIDTH(VAL_W),
		.DEPTH(NUM_TIMERS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stop_q      <= '0;
			prescaler_q <= '0;
			frame_q     <= '0;
			vld_q       <= '0;
			rd_vld_s1   <= 1'b0;
			cnt_q       <= '0;
			lim_q       <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (accept) begin
				case (req.op)
					OP_TICK: begin
						stop_q  <= stop_dec;
						frame_q <= frame_q + 8'd1;
						cnt_q   <= '0;
						lim_q   <= tick_slow ? CNT_W'(NUM_TIMERS) : CNT_W'(FAST_EFF);
						if (!tick_skip) begin
							prescaler_q <= tick_slow ? {1'b0, req.reload} : pre_dec;
						end
					end
					OP_WR_STOP: stop_q <= req.wval;
					default:    ;
				endcase
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		rd_addr_s1 <= cnt_q[TMR_AW-1:0];
		if (accept) begin
			addr_q     <= TMR_AW'(req.idx);
			inr_q      <= in_range;
			read_val_q <= '0;
			skip_q     <= (req.op == OP_TICK) && tick_skip;
			slow_q     <= (req.op == OP_TICK) && tick_slow;
		end
		if (state_q == ST_RDWAIT) begin
			read_val_q <= (inr_q && vld_q[addr_q]) ? ram_rdata : '0;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr != ram_raddr)
		else $error("read and write hit the same timer");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP |-> cnt_q <= lim_q)
		else $error("sweep counter past its limit");
	a_s1_from_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q) == ST_SWEEP)
		else $error("write-back outside a sweep");
	a_done_after_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP && cnt_q == lim_q |=> state_q == ST_DONE && !rd_vld_s1)
		else $error("sweep did not drain");
`endif

endmodule

>>> rtl/prescaled_countdown_timer_bank.sv
// prescaled countdown timer bank
//
// input stream s_axis: one item per transfer, tuser carries the operation
// (frame tick, timer write, timer read, stop counter write), tdata the timer
// index and write value. output stream m_axis: one result per item with the
// frame counter, its zero and negative flags, the read value and the skip and
// slow-tick flags.
// cfg channel: writes the 7-bit prescaler reload, accepted in any cycle;
// change it only while the bank is idle.
// a frame tick walks the timer memory one entry per cycle through a
// read-decrement-write pipeline over N entries, N being the fast group (21)
// or, on a slow tick, the whole bank (36); a skipped tick, a write or a stop
// counter write goes straight to its result, a read waits on the memory. the
// next item is taken the cycle after the result moves to the output register.
// reset clears all timers, the prescaler, stop and frame counters at once and
// sets the reload to 20. a stalled m_axis holds its result; the bank finishes
// one more item behind it and then waits until m_axis_tready.
module prescaled_countdown_timer_bank (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // timer_index, write_value, zero pad
	input  logic [1:0]  s_axis_tuser,  // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // frame_num, frame_zero, frame_negative,
	                                   // read_value, bank_skipped, slow_tick, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [pctb_pkg::RELOAD_W-1:0] cfg_data
);
	import pctb_pkg::*;

	logic [RELOAD_W-1:0] reload_q;
	req_t                req;
	res_t                res;
	logic                out_free;
	logic                m_vld_q;
	logic [23:0]         m_data_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= RELOAD_RST;
		end else if (cfg_valid && cfg_ready) begin
			reload_q <= cfg_data;
		end
	end

	assign req = {op_t'(s_axis_tuser), s_axis_tdata[5:0], s_axis_tdata[13:6], reload_q};

	assign out_free = !m_vld_q || m_axis_tready;

	pctb_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(s_axis_tvalid),
		.req      (req),
		.req_ready(s_axis_tready),
		.res_take (out_free),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (out_free) begin
			m_vld_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid) begin
			m_data_q <= {4'b0, res.slow, res.skipped, res.read_value,
				res.frame_num[7], (res.frame_num == '0), res.frame_num};
		end
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = m_data_q;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import pctb_pkg::*;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] wval;
	} timer_cmd_t;

	typedef struct packed {
		logic [7:0] frame_num;
		logic       frame_zero;
		logic       frame_negative;
		logic [7:0] read_value;
		logic       bank_skipped;
		logic       slow_tick;
	} timer_result_t;

	localparam int LONG_HOLD = 400;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [15:0]         s_axis_tdata = '0;
	logic [1:0]          s_axis_tuser = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [23:0]         m_axis_tdata;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [RELOAD_W-1:0] cfg_data = '0;

	timer_cmd_t    pending_cmds[$];
	timer_result_t expected_results[$];

	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int mismatches = 0;

	// model state of the bank
	logic [7:0]          timer_bank[NUM_TIMERS];
	logic [7:0]          prescaler = 8'd0;
	logic [7:0]          stop_count = 8'd0;
	logic [7:0]          frame_num = 8'd0;
	logic [RELOAD_W-1:0] reload_setting = RELOAD_RST;

	prescaled_countdown_timer_bank dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < NUM_TIMERS; i++)
			timer_bank[i] = 8'd0;
	end

	function automatic timer_result_t apply_timer_cmd(op_t op, logic [IDX_W-1:0] idx,
			logic [VAL_W-1:0] wval);
		timer_result_t r;
		int n;
		r = '0;
		case (op)
			OP_TICK: begin
				if (stop_count != 8'd0) begin
					stop_count = stop_count - 8'd1;
					if (stop_count != 8'd0)
						r.bank_skipped = 1'b1;
				end
				if (!r.bank_skipped) begin
					prescaler = prescaler - 8'd1;
					if (prescaler[7]) begin
						prescaler = {1'b0, reload_setting};
						r.slow_tick = 1'b1;
						n = NUM_TIMERS;
					end else begin
						n = (FAST_TIMERS > NUM_TIMERS) ? NUM_TIMERS : FAST_TIMERS;
					end
					for (int i = 0; i < n; i++)
						if (timer_bank[i] != 8'd0)
							timer_bank[i] = timer_bank[i] - 8'd1;
				end
				frame_num = frame_num + 8'd1;
			end
			OP_WR_TIMER: begin
				if (idx < NUM_TIMERS)
					timer_bank[idx] = wval;
			end
			OP_RD_TIMER: begin
				if (idx < NUM_TIMERS)
					r.read_value = timer_bank[idx];
			end
			default: begin
				stop_count = wval;
			end
		endcase
		r.frame_num = frame_num;
		r.frame_zero = (frame_num == 8'd0);
		r.frame_negative = frame_num[7];
		return r;
	endfunction

	function automatic timer_cmd_t random_cmd();
		timer_cmd_t c;
		int pick;
		pick = $urandom_range(99);
		if ($urandom_range(9) == 0)
			c.idx = IDX_W'($urandom_range(63, NUM_TIMERS));
		else
			c.idx = IDX_W'($urandom_range(NUM_TIMERS - 1));
		if ($urandom_range(3) == 0)
			c.wval = VAL_W'($urandom_range(3));
		else
			c.wval = VAL_W'($urandom);
		if (pick < 42) begin
			c.op = OP_TICK;
		end else if (pick < 67) begin
			c.op = OP_WR_TIMER;
		end else if (pick < 92) begin
			c.op = OP_RD_TIMER;
		end else begin
			c.op = OP_WR_STOP;
			if ($urandom_range(7) != 0)
				c.wval = VAL_W'($urandom_range(4));
		end
		return c;
	endfunction

	task automatic queue_cmd(op_t op, int idx, int wval);
		timer_cmd_t c;
		c.op = op;
		c.idx = IDX_W'(idx);
		c.wval = VAL_W'(wval);
		pending_cmds.push_back(c);
	endtask

	task automatic queue_random(int count);
		repeat (count) pending_cmds.push_back(random_cmd());
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_cmds.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
	endtask

	task automatic write_reload(logic [RELOAD_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		reload_setting = value;
	endtask

	task automatic check_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			mismatches++;
		end
	endtask

	// sender: predict on each accepted transfer, then offer the next command
	always @(posedge clk) begin
		timer_cmd_t c;
		if (s_axis_tvalid && s_axis_tready)
			expected_results.push_back(apply_timer_cmd(op_t'(s_axis_tuser),
				s_axis_tdata[5:0], s_axis_tdata[13:6]));
		if (!s_axis_tvalid || s_axis_tready) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				c = pending_cmds.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= c.op;
				s_axis_tdata <= {2'b00, c.wval, c.idx};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: compare results and drive backpressure
	always @(posedge clk) begin
		timer_result_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected: %h", m_axis_tdata);
				mismatches++;
			end else begin
				e = expected_results.pop_front();
				check_field("frame_num", e.frame_num, m_axis_tdata[7:0]);
				check_field("frame_zero", e.frame_zero, m_axis_tdata[8]);
				check_field("frame_negative", e.frame_negative, m_axis_tdata[9]);
				check_field("read_value", e.read_value, m_axis_tdata[17:10]);
				check_field("bank_skipped", e.bank_skipped, m_axis_tdata[18]);
				check_field("slow_tick", e.slow_tick, m_axis_tdata[19]);
			end
		end
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_gap_pct = 15;
		recv_gap_pct = 54;

		// directed: reads after reset, range edges, stop counter cases
		queue_cmd(OP_RD_TIMER, 0, 0);
		queue_cmd(OP_RD_TIMER, NUM_TIMERS - 1, 0);
		queue_cmd(OP_WR_TIMER, 0, 255);
		queue_cmd(OP_WR_TIMER, NUM_TIMERS - 1, 1);
		queue_cmd(OP_WR_TIMER, FAST_TIMERS - 1, 2);
		queue_cmd(OP_WR_TIMER, FAST_TIMERS, 3);
		queue_cmd(OP_WR_TIMER, NUM_TIMERS, 8'hAA);
		queue_cmd(OP_WR_TIMER, 63, 8'h55);
		queue_cmd(OP_TICK, 0, 0);
		queue_cmd(OP_TICK, 63, 255);
		queue_cmd(OP_RD_TIMER, FAST_TIMERS - 1, 0);
		queue_cmd(OP_RD_TIMER, FAST_TIMERS, 0);
		queue_cmd(OP_RD_TIMER, NUM_TIMERS - 1, 0);
		queue_cmd(OP_RD_TIMER, NUM_TIMERS, 0);
		queue_cmd(OP_RD_TIMER, 63, 255);
		queue_cmd(OP_WR_STOP, 0, 1);
		queue_cmd(OP_TICK, 0, 0);
		queue_cmd(OP_WR_STOP, 0, 3);
		queue_cmd(OP_TICK, 0, 0);
		queue_cmd(OP_TICK, 0, 0);
		queue_cmd(OP_TICK, 0, 0);
		queue_cmd(OP_WR_STOP, 0, 0);
		queue_cmd(OP_TICK, 0, 0);
		queue_cmd(OP_RD_TIMER, 0, 0);
		queue_cmd(OP_WR_STOP, 0, 255);
		wait_drained();

		write_reload(7'd0);
		@(negedge clk);
		queue_random(250);
		// sender pause until the bank has delivered everything
		wait_drained();
		queue_random(250);
		wait_drained();

		send_gap_pct = 54;
		recv_gap_pct = 15;
		write_reload(7'h7F);
		@(negedge clk);
		queue_random(500);
		wait_drained();

		send_gap_pct = 0;
		recv_gap_pct = 0;
		write_reload(RELOAD_W'($urandom_range(126, 1)));
		@(negedge clk);
		queue_random(450);
		hold_req = hold_req + 1;
		wait_drained();

		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
